// ----- hw/rtl/interpolating_sample_player_top_macros.svh -----
// Assertion macros used by the sample player top level.
`ifndef INTERPOLATING_SAMPLE_PLAYER_TOP_MACROS_SVH
`define INTERPOLATING_SAMPLE_PLAYER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ISPL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ISPL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ispl_pkg.sv -----
// Types and constants of the interpolating sample player.
package ispl_pkg;

    localparam int MEM_DEPTH_DEF    = 65536;
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 17;
    localparam int STEP_W   = 24;
    localparam int CC_W     = 4;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [POS_W-1:0]  POS_MAX   = 17'h1FFFF;
    localparam logic [STEP_W-1:0] STEP_RST  = 24'h010000;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_SEEK  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STEP          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TOTAL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    typedef struct packed {
        logic [1:0]                 op;
        logic [15:0]                address;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [15:0]                seek_frame;
    } t_item;

    typedef struct packed {
        logic [2:0]                 channel;
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       last;
        logic                       ended;
        logic [POS_W-1:0]           frame_position;
    } t_result;

    // Tag that follows a channel through the interpolation datapath.
    typedef struct packed {
        logic       valid;
        logic [2:0] channel;
        logic       last;
    } t_lerp_tag;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_READ,
        ST_DRAIN,
        ST_ENDED
    } t_state;

endpackage

// ----- hw/rtl/ispl_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
module ispl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/ispl_mod_reduce.sv -----
// Reduction of an index modulo the memory depth by reciprocal multiplication.
module ispl_mod_reduce
    import ispl_pkg::*;
#(
    parameter int PROD_W    = 22,
    parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [PROD_W-1:0]            i_value,
    output logic                         o_done,
    output logic [$clog2(MEM_DEPTH)-1:0] o_rem
);

    localparam int     AW    = $clog2(MEM_DEPTH);
    localparam int     SH    = PROD_W + AW;
    localparam int     M_W   = PROD_W + 2;
    localparam int     Q_W   = (PROD_W >= AW) ? (PROD_W - AW + 1) : 1;
    localparam int     MP_W  = PROD_W + M_W;
    localparam int     WW    = PROD_W + AW + 2;
    // The reciprocal is rounded up, which makes the quotient exact for every value
    // below 2**PROD_W.
    localparam longint RECIP = ((longint'(1) << SH) + longint'(MEM_DEPTH) - 1)
                               / longint'(MEM_DEPTH);

    logic [PROD_W-1:0] r_val;
    logic [Q_W-1:0]    r_q;
    logic [AW-1:0]     r_rem;
    logic              r_v1;
    logic              r_v2;
    logic              r_done;
    logic [MP_W-1:0]   prod;
    logic [WW-1:0]     back;

    always_comb begin
        prod = MP_W'(r_val) * MP_W'(M_W'(RECIP));
        back = WW'(r_val) - WW'(r_q) * WW'(MEM_DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_done <= r_v2;
        end
    end

    // Value, then quotient, then remainder, each held in its own register stage.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
        end
        if (r_v1) begin
            r_q <= Q_W'(prod >> SH);
        end
        if (r_v2) begin
            r_rem <= AW'(back);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- hw/rtl/ispl_lerp.sv -----
// Linear interpolation datapath: difference times fraction, then round.
module ispl_lerp
    import ispl_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_lerp_tag                   i_tag,
    input  logic signed [SAMPLE_W-1:0]  i_a,
    input  logic signed [SAMPLE_W-1:0]  i_b,
    input  logic [FRAC_BITS-1:0]        i_frac,
    output t_lerp_tag                   o_tag,
    output logic signed [SAMPLE_W-1:0]  o_sample
);

    localparam int DW = SAMPLE_W + 1;
    localparam int PW = DW + FRAC_BITS + 1;
    localparam int SW = PW + 1;

    logic signed [DW-1:0]       diff;
    logic signed [PW-1:0]       n_mul;
    logic signed [PW-1:0]       r_mul;
    logic signed [SAMPLE_W-1:0] r_a;
    t_lerp_tag                  r_tag;
    logic signed [SW-1:0]       sum;
    logic signed [SW-1:0]       rnd;

    // a*(1-f) + b*f is rewritten as a + (b-a)*f so one multiplier suffices.
    always_comb begin
        diff  = DW'(i_b) - DW'(i_a);
        n_mul = PW'(diff) * PW'($signed({1'b0, i_frac}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else begin
            r_tag.valid <= i_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag.channel <= i_tag.channel;
        r_tag.last    <= i_tag.last;
        r_mul         <= n_mul;
        r_a           <= i_a;
    end

    // Adding one half before the arithmetic shift rounds half toward plus infinity.
    always_comb begin
        sum = (SW'(r_a) <<< FRAC_BITS) + SW'(r_mul) + (SW'(1) <<< (FRAC_BITS - 1));
        rnd = sum >>> FRAC_BITS;
    end

    assign o_tag    = r_tag;
    assign o_sample = $signed(rnd[SAMPLE_W-1:0]);

endmodule

// ----- hw/rtl/interpolating_sample_player_top.sv -----
// Top level of the interpolating sample player: control, registers and memory.

// A write reduces the memory index modulo the memory depth by a three-stage
// reciprocal multiplication before the single write. A seek is taken without leaving
// the idle state. A tick on a playing voice waits for the index reduction and is paced
// by the single memory port that serves two sample reads per channel; a tick after the
// end emits one silent result per channel. Results leave one per cycle
// at most, each shown for exactly one cycle with o_strobe, and the receiver cannot
// stall them. start is taken only while busy is low; configuration writes are taken
// in any cycle and must be issued only while the block is idle.
`include "interpolating_sample_player_top_macros.svh"

module interpolating_sample_player_top
    import ispl_pkg::*;
#(
    parameter int MEM_DEPTH    = MEM_DEPTH_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_item                i_item,
    output logic                 o_strobe,
    output t_result              o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW     = $clog2(MEM_DEPTH);
    localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PROD_W = POS_W + NCH_W;
    localparam int ACC_W  = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;
    localparam int NP_W   = ACC_W + 1;

    t_state r_state, n_state;

    logic [STEP_W-1:0]    r_step;
    logic [POS_W-1:0]     r_total;
    logic [CC_W-1:0]      r_cc;

    logic [POS_W-1:0]     r_pos;
    logic [FRAC_BITS-1:0] r_frac;
    logic                 r_ended_flag;

    logic [POS_W-1:0]     r_pos_before;
    logic [FRAC_BITS-1:0] r_frac_use;
    logic                 r_clamp;
    logic [NCH_W-1:0]     r_nch;
    logic                 r_is_write;
    logic [SAMPLE_W-1:0]  r_wdata;
    logic [AW-1:0]        r_addr_a;
    logic [AW-1:0]        r_addr_b;
    logic [CH_W-1:0]      r_j;
    logic                 r_phase;
    t_lerp_tag            r_p1;
    logic                 r_p1_is_b;
    logic signed [SAMPLE_W-1:0] r_a;
    t_result              r_result;
    logic                 r_strobe;

    logic                 accept;
    logic                 at_end;
    logic [NCH_W-1:0]     nch_cur;
    logic                 last_j;
    logic                 red_start;
    logic                 red_done;
    logic [AW-1:0]        red_rem;
    logic [PROD_W-1:0]    red_value;
    logic                 issue;
    logic                 ram_we;
    logic                 emit_end;
    logic [AW-1:0]        ram_addr;
    logic [SAMPLE_W-1:0]  ram_rdata;
    logic [AW:0]          base_sum;
    logic [AW-1:0]        base_b;
    logic [ACC_W-1:0]     acc;
    logic [NP_W-1:0]      np;
    t_lerp_tag            lerp_in;
    t_lerp_tag            lerp_out;
    logic signed [SAMPLE_W-1:0] lerp_sample;

    assign accept      = start && (r_state == ST_IDLE);
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        priority if (r_cc == '0) begin
            nch_cur = NCH_W'(1);
        end else if ((NCH_W + CC_W)'(r_cc) > (NCH_W + CC_W)'(MAX_CHANNELS)) begin
            nch_cur = NCH_W'(MAX_CHANNELS);
        end else begin
            nch_cur = NCH_W'(r_cc);
        end
    end

    assign at_end = r_ended_flag || (r_pos >= r_total);
    assign last_j = ((NCH_W'(r_j) + NCH_W'(1)) == r_nch);

    // Fraction advance; the integer carry moves the frame position, saturating.
    always_comb begin
        acc = ACC_W'(r_frac) + ACC_W'(r_step);
        np  = NP_W'(r_pos) + NP_W'(acc >> FRAC_BITS);
    end

    assign red_value = (i_item.op == OP_WRITE) ? PROD_W'(i_item.address)
                                               : PROD_W'(r_pos) * PROD_W'(nch_cur);

    // Base of the next frame: one frame of channels further, wrapped once, or the same frame when clamped.
    always_comb begin
        base_sum = (AW + 1)'(red_rem) + (AW + 1)'(r_nch);
        if (base_sum >= (AW + 1)'(MEM_DEPTH)) begin
            base_sum = base_sum - (AW + 1)'(MEM_DEPTH);
        end
        base_b = r_clamp ? red_rem : AW'(base_sum);
    end

    always_comb begin
        n_state   = r_state;
        red_start = 1'b0;
        issue     = 1'b0;
        ram_we    = 1'b0;
        emit_end  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (i_item.op)
                        OP_WRITE: begin
                            red_start = 1'b1;
                            n_state   = ST_REDUCE;
                        end
                        OP_TICK: begin
                            if (at_end) begin
                                n_state = ST_ENDED;
                            end else begin
                                red_start = 1'b1;
                                n_state   = ST_REDUCE;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_REDUCE: begin
                if (red_done) begin
                    if (r_is_write) begin
                        ram_we  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                issue = 1'b1;
                if (r_phase && last_j) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (lerp_out.valid && lerp_out.last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ENDED: begin
                emit_end = 1'b1;
                if (last_j) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers and play state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= STEP_RST;
            r_total      <= '0;
            r_cc         <= CC_W'(1);
            r_pos        <= '0;
            r_frac       <= '0;
            r_ended_flag <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_STEP:          r_step  <= i_cfg_data[STEP_W-1:0];
                    REG_FRAME_TOTAL:   r_total <= i_cfg_data[POS_W-1:0];
                    REG_CHANNEL_COUNT: r_cc    <= i_cfg_data[CC_W-1:0];
                    default: begin
                        r_step <= r_step;
                    end
                endcase
            end
            if (accept) begin
                unique case (i_item.op)
                    OP_SEEK: begin
                        r_pos        <= POS_W'(i_item.seek_frame);
                        r_frac       <= '0;
                        r_ended_flag <= 1'b0;
                    end
                    OP_TICK: begin
                        if (at_end) begin
                            r_ended_flag <= 1'b1;
                        end else begin
                            r_pos  <= (np > NP_W'(POS_MAX)) ? POS_MAX : POS_W'(np);
                            r_frac <= acc[FRAC_BITS-1:0];
                        end
                    end
                    default: begin
                        r_pos <= r_pos;
                    end
                endcase
            end
        end
    end

    // Sequencing state of the current transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j        <= '0;
            r_phase    <= 1'b0;
            r_p1.valid <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= lerp_out.valid || emit_end;
            if (accept) begin
                r_j     <= '0;
                r_phase <= 1'b0;
            end else if (issue) begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    r_j <= r_j + CH_W'(1);
                end
            end else if (emit_end) begin
                r_j <= r_j + CH_W'(1);
            end
            r_p1.valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos_before <= r_pos;
            r_frac_use   <= r_frac;
            r_clamp      <= ((POS_W + 1)'(r_pos) + (POS_W + 1)'(1)) >= (POS_W + 1)'(r_total);
            r_nch        <= nch_cur;
            r_is_write   <= (i_item.op == OP_WRITE);
            r_wdata      <= i_item.sample_in;
        end
        if ((r_state == ST_REDUCE) && red_done) begin
            r_addr_a <= red_rem;
            r_addr_b <= base_b;
        end else if (issue && r_phase) begin
            r_addr_a <= (r_addr_a == AW'(MEM_DEPTH - 1)) ? '0 : r_addr_a + AW'(1);
            r_addr_b <= (r_addr_b == AW'(MEM_DEPTH - 1)) ? '0 : r_addr_b + AW'(1);
        end
        r_p1.channel <= 3'(r_j);
        r_p1.last    <= last_j;
        r_p1_is_b    <= r_phase;
        if (r_p1.valid && !r_p1_is_b) begin
            r_a <= $signed(ram_rdata);
        end
        if (emit_end) begin
            r_result.channel        <= 3'(r_j);
            r_result.sample_out     <= '0;
            r_result.last           <= last_j;
            r_result.ended          <= 1'b1;
            r_result.frame_position <= r_pos_before;
        end else begin
            r_result.channel        <= lerp_out.channel;
            r_result.sample_out     <= lerp_sample;
            r_result.last           <= lerp_out.last;
            r_result.ended          <= 1'b0;
            r_result.frame_position <= r_pos_before;
        end
    end

    // Reads and writes never overlap: a write completes before busy drops, so the
    // next transaction always sees it without forwarding.
    assign ram_addr = ram_we ? red_rem : (r_phase ? r_addr_b : r_addr_a);

    ispl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_wdata),
        .o_rdata (ram_rdata)
    );

    ispl_mod_reduce #(
        .PROD_W    (PROD_W),
        .MEM_DEPTH (MEM_DEPTH)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (red_start),
        .i_value (red_value),
        .o_done  (red_done),
        .o_rem   (red_rem)
    );

    always_comb begin
        lerp_in.valid   = r_p1.valid && r_p1_is_b;
        lerp_in.channel = r_p1.channel;
        lerp_in.last    = r_p1.last;
    end

    ispl_lerp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lerp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (lerp_in),
        .i_a      (r_a),
        .i_b      ($signed(ram_rdata)),
        .i_frac   (r_frac_use),
        .o_tag    (lerp_out),
        .o_sample (lerp_sample)
    );

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `ISPL_ASSERT_SAME(a_ended_is_silent, o_strobe && o_result.ended, o_result.sample_out == '0, "ended result is not silent")
    `ISPL_ASSERT_NEXT(a_gap_after_last, o_strobe && o_result.last, !o_strobe, "result follows last channel without gap")
    `ISPL_ASSERT_SAME(a_busy_mid_frame, o_strobe && !o_result.last, busy, "idle while a frame is incomplete")
    `ISPL_ASSERT_SAME(a_reduce_in_state, red_done, r_state == ST_REDUCE, "index reduction finished outside its state")
    `ISPL_ASSERT_SAME(a_ended_flag_set, o_strobe && o_result.ended, r_ended_flag, "ended result without ended flag")

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench of the interpolating sample player top level.
`timescale 1ns / 100ps

module tb
    import ispl_pkg::*;
;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         QUIET_LIMIT   = 2000;
    localparam int         PHASE_ITEMS   = 36;

    // Tracks the player state and the output samples each tick must produce.
    class sample_player_scoreboard;
        logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH_DEF];
        bit                         written [MEM_DEPTH_DEF];
        logic [POS_W-1:0]           pos;
        logic [15:0]                frac;
        bit                         ended_flag;
        logic [STEP_W-1:0]          frame_step;
        logic [POS_W-1:0]           frame_total;
        logic [CC_W-1:0]            chans;
        t_result                    expected_samples[$];
        int                         errors;

        function new();
            pos         = '0;
            frac        = '0;
            ended_flag  = 1'b0;
            frame_step  = STEP_RST;
            frame_total = '0;
            chans       = CC_W'(1);
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_STEP:          frame_step  = data[STEP_W-1:0];
                REG_FRAME_TOTAL:   frame_total = data[POS_W-1:0];
                REG_CHANNEL_COUNT: chans       = data[CC_W-1:0];
                default: ;
            endcase
        endfunction

        function int active_channels();
            if (chans == 0) return 1;
            if (chans > MAX_CHANNELS_DEF) return MAX_CHANNELS_DEF;
            return int'(chans);
        endfunction

        function bit at_end();
            return ended_flag || (pos >= frame_total);
        endfunction

        // The second interpolation point is clamped to the last loaded frame.
        function logic [POS_W-1:0] next_frame();
            if ({1'b0, pos} + 18'd1 >= {1'b0, frame_total}) return pos;
            return pos + 1'b1;
        endfunction

        function logic [15:0] read_index(logic [POS_W-1:0] frame, int j);
            int unsigned flat;
            flat = frame * active_channels() + j;
            return flat[15:0];
        endfunction

        function void play_tick();
            int               nch;
            t_result          r;
            logic [POS_W-1:0] nxt;
            longint           a;
            longint           b;
            longint           mix;
            logic [24:0]      acc;
            logic [17:0]      adv;
            nch = active_channels();
            if (at_end()) begin
                ended_flag = 1'b1;
                for (int j = 0; j < nch; j++) begin
                    r.channel        = 3'(j);
                    r.sample_out     = '0;
                    r.last           = (j == nch - 1);
                    r.ended          = 1'b1;
                    r.frame_position = pos;
                    expected_samples.push_back(r);
                end
                return;
            end
            nxt = next_frame();
            for (int j = 0; j < nch; j++) begin
                a   = mem[read_index(pos, j)];
                b   = mem[read_index(nxt, j)];
                mix = a * (64'sd65536 - longint'(frac)) + b * longint'(frac) + 64'sd32768;
                r.channel        = 3'(j);
                r.sample_out     = SAMPLE_W'(mix >>> FRAC_BITS_DEF);
                r.last           = (j == nch - 1);
                r.ended          = 1'b0;
                r.frame_position = pos;
                expected_samples.push_back(r);
            end
            acc = 25'(frac) + 25'(frame_step);
            adv = 18'(pos) + 18'(acc[24:16]);
            if (adv > 18'(POS_MAX)) adv = 18'(POS_MAX);
            pos  = adv[POS_W-1:0];
            frac = acc[15:0];
        endfunction

        function void note_item(t_item it);
            case (it.op)
                OP_WRITE: begin
                    mem[it.address]     = it.sample_in;
                    written[it.address] = 1'b1;
                end
                OP_SEEK: begin
                    pos        = {1'b0, it.seek_frame};
                    frac       = '0;
                    ended_flag = 1'b0;
                end
                OP_TICK: play_tick();
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_sample(t_result got);
            t_result want;
            if (expected_samples.size() == 0) begin
                $error("unexpected result: channel %0d sample %0d", got.channel,
                       got.sample_out);
                errors++;
                return;
            end
            want = expected_samples.pop_front();
            compare_field("channel", want.channel, got.channel);
            compare_field("sample_out", want.sample_out, got.sample_out);
            compare_field("last", want.last, got.last);
            compare_field("ended", want.ended, got.ended);
            compare_field("frame_position", want.frame_position, got.frame_position);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_item                i_item;
    logic                 o_strobe;
    t_result              o_result;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    sample_player_scoreboard sb = new();
    int                      gap_pct;
    int                      quiet_cycles;
    int                      sent_items;

    interpolating_sample_player_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Results are checked here; the watchdog ends a run that stops making progress.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (o_strobe) sb.check_sample(o_result);
            if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic t_item random_item();
        t_item it;
        it.op         = 2'($urandom_range(0, 3));
        it.address    = 16'($urandom);
        it.sample_in  = 16'($urandom);
        it.seek_frame = 16'($urandom);
        return it;
    endfunction

    // Start stays high from one transaction to the next unless a gap is drawn.
    task automatic send_item(input t_item it);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_item(it);
        sent_items++;
    endtask

    task automatic send_write(input logic [15:0] addr, input logic signed [15:0] value);
        t_item it;
        it           = random_item();
        it.op        = OP_WRITE;
        it.address   = addr;
        it.sample_in = value;
        send_item(it);
    endtask

    task automatic send_seek(input logic [15:0] frame);
        t_item it;
        it            = random_item();
        it.op         = OP_SEEK;
        it.seek_frame = frame;
        send_item(it);
    endtask

    // Loads any sample the coming tick would read before it has ever been written.
    task automatic tick();
        logic [POS_W-1:0] frames [2];
        logic [15:0]      idx;
        t_item            it;
        if (!sb.at_end()) begin
            frames[0] = sb.pos;
            frames[1] = sb.next_frame();
            for (int k = 0; k < 2; k++) begin
                for (int j = 0; j < sb.active_channels(); j++) begin
                    idx = sb.read_index(frames[k], j);
                    if (!sb.written[idx]) send_write(idx, 16'($urandom));
                end
            end
        end
        it    = random_item();
        it.op = OP_TICK;
        send_item(it);
    endtask

    // Writes and seeks produce no results, so the block may still be busy after the
    // last expected sample; give it time to finish before touching the registers.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.expected_samples.size() != 0 || busy) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input logic [STEP_W-1:0] step_val,
                             input logic [POS_W-1:0] total_val,
                             input logic [CC_W-1:0] chans_val);
        logic [CFG_IDX_W-1:0] regs [3];
        logic [CFG_W-1:0]     vals [3];
        regs = '{REG_STEP, REG_FRAME_TOTAL, REG_CHANNEL_COUNT};
        vals = '{CFG_W'(step_val), CFG_W'(total_val), CFG_W'(chans_val)};
        drain();
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.set_reg(regs[k], vals[k]);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] edge_samples [8];
        int          gap_plan [4];
        int          phase_start;
        int          pick;
        t_item       it;

        edge_samples = '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                         16'hFFFF, 16'h0000, 16'h0000, 16'h0001};
        gap_plan     = '{0, 54, 0, 25};
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        gap_pct      = 0;
        sent_items   = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Two channels at half speed over four frames: full-scale swings, rounding of
        // exact halves, the clamp on the last frame and the end of the sample.
        configure(24'h008000, 17'd4, 4'd2);
        for (int k = 0; k < 8; k++) send_write(16'(k), edge_samples[k]);
        repeat (10) tick();
        // The ended flag persists even once the position is back inside the range.
        configure(24'h008000, 17'd8, 4'd2);
        tick();
        send_seek(16'd2);
        tick();
        it    = random_item();
        it.op = OP_UNUSED;
        send_item(it);
        send_write(16'hFFFF, 16'h7FFF);

        // Every transaction counts toward the phase budget, sample preloads included.
        for (int p = 0; p < 8; p++) begin
            gap_pct = gap_plan[p % 4];
            case (p)
                0: configure(24'd0, 17'd65536, 4'd8);
                1: configure(24'hFFFFFF, 17'd3, 4'd1);
                2: configure(24'($urandom), 17'd0, 4'd0);
                3: configure(24'($urandom_range(0, 24'h030000)),
                             17'($urandom_range(1, 40)), 4'd15);
                4: configure(24'($urandom), 17'($urandom_range(32768, 65535)),
                             4'($urandom_range(1, 8)));
                default: configure(24'($urandom_range(0, 24'h028000)),
                                   17'($urandom_range(1, 48)), 4'($urandom_range(1, 8)));
            endcase
            phase_start = sent_items;
            while (sent_items - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    send_write(16'($urandom), 16'($urandom));
                end else if (pick < 22) begin
                    if (sb.frame_total != 0 && $urandom_range(0, 3) != 0)
                        send_seek(16'($urandom_range(0, sb.frame_total - 1)));
                    else
                        send_seek(16'($urandom));
                end else if (pick < 96) begin
                    tick();
                end else begin
                    it    = random_item();
                    it.op = OP_UNUSED;
                    send_item(it);
                end
            end
        end

        drain();
        if (sb.errors == 0 && sb.expected_samples.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
